// ----- design/slcc_pkg.sv -----
// Shared widths, function codes and sizes for the span link conflict counter.
package slcc_pkg;

  // Link store geometry
  localparam int MAX_WORDS = 64;
  localparam int IDX_W     = $clog2(MAX_WORDS);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 6;
  localparam int LINK_W  = 7;
  localparam int START_W = 6;
  localparam int END_W   = 7;
  localparam int CNT_W   = 8;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_SRC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_TGT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

  // Range ends above the store size are clipped to it
  localparam logic [END_W-1:0] END_MAX = END_W'(MAX_WORDS);

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// ----- design/span_link_conflict_counter_top.sv -----
// Top level: link stores, query walk sequencer and result register.
//
// Link writes (func 0 and 1) are stored when accepted; func 3 is accepted and dropped.
// A query walks every word position of both link stores, one source and one
// target entry per cycle through a single read port on each store; the walk
// is followed by the flush and done states, and the result is loaded into the
// output register from the done state; input ready is low meanwhile.
// A finished result waits in the output register while new writes are taken;
// the next query's result is held back until the previous one has been taken.
// The link stores have no reset: querying a never-written entry gives an
// arbitrary contribution. conflict_limit may be written at any idle time and
// sets prune when the count exceeds it.
module span_link_conflict_counter_top (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slcc_pkg::CNT_W-1:0]       cfg_data,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [slcc_pkg::FUNC_W-1:0]      func,
  input  logic [slcc_pkg::POS_W-1:0]       position,
  input  logic signed [slcc_pkg::LINK_W-1:0] link,
  input  logic [slcc_pkg::START_W-1:0]     span_e_start,
  input  logic [slcc_pkg::END_W-1:0]       span_e_end,
  input  logic [slcc_pkg::START_W-1:0]     span_c_start,
  input  logic [slcc_pkg::END_W-1:0]       span_c_end,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [slcc_pkg::CNT_W-1:0]       conflict_count,
  output logic                             prune
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [slcc_pkg::IDX_W-1:0] IDX_LAST =
    slcc_pkg::IDX_W'(slcc_pkg::MAX_WORDS - 1);

  logic [1:0]                        state;
  logic [1:0]                        state_next;
  logic [slcc_pkg::IDX_W-1:0]        idx;
  logic [slcc_pkg::IDX_W-1:0]        rd_idx;
  logic                              rd_valid;
  slcc_pkg::link_t                   rd_src;
  slcc_pkg::link_t                   rd_tgt;
  slcc_pkg::cnt_t                    cnt;
  slcc_pkg::cnt_t                    cnt_next;
  slcc_pkg::cnt_t                    conflict_limit;
  logic [slcc_pkg::START_W-1:0]      q_es;
  logic [slcc_pkg::END_W-1:0]        q_ee;
  logic [slcc_pkg::START_W-1:0]      q_cs;
  logic [slcc_pkg::END_W-1:0]        q_ce;
  slcc_pkg::cnt_t                    out_cnt;

  slcc_pkg::link_t src_mem [slcc_pkg::MAX_WORDS];
  slcc_pkg::link_t tgt_mem [slcc_pkg::MAX_WORDS];

  logic in_acc;
  logic out_acc;
  logic out_free;
  logic src_hit;
  logic tgt_hit;
  logic [slcc_pkg::END_W-1:0] rd_pos;

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // Hold the conflict limit
  always_ff @(posedge clk) begin
    if (rst) begin
      conflict_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      conflict_limit <= cfg_data;
    end
  end

  // Write links on accepted write items
  always_ff @(posedge clk) begin
    if (in_acc && (func == slcc_pkg::FUNC_WR_SRC)) begin
      src_mem[position] <= link;
    end
    if (in_acc && (func == slcc_pkg::FUNC_WR_TGT)) begin
      tgt_mem[position] <= link;
    end
  end

  // Read one entry of each store per walk cycle
  always_ff @(posedge clk) begin
    if (state == ST_WALK) begin
      rd_src <= src_mem[idx];
      rd_tgt <= tgt_mem[idx];
      rd_idx <= idx;
    end
  end

  // Latch query ranges, clipping ends to the store size
  always_ff @(posedge clk) begin
    if (in_acc && (func == slcc_pkg::FUNC_QUERY)) begin
      q_es <= span_e_start;
      q_cs <= span_c_start;
      q_ee <= (span_e_end > slcc_pkg::END_MAX) ? slcc_pkg::END_MAX : span_e_end;
      q_ce <= (span_c_end > slcc_pkg::END_MAX) ? slcc_pkg::END_MAX : span_c_end;
    end
  end

  // Classify the word just read on each side
  always_comb begin
    rd_pos  = {1'b0, rd_idx};
    src_hit = (rd_pos >= {1'b0, q_cs}) && (rd_pos < q_ce) && !rd_src[slcc_pkg::LINK_W-1]
              && ((rd_src >= q_ee) || (rd_src < {1'b0, q_es}));
    tgt_hit = (rd_pos >= {1'b0, q_es}) && (rd_pos < q_ee) && !rd_tgt[slcc_pkg::LINK_W-1]
              && ((rd_tgt >= q_ce) || (rd_tgt < {1'b0, q_cs}));
    // At most two hits per word, so the count never passes 2 * MAX_WORDS
    cnt_next = cnt;
    if (rd_valid) begin
      cnt_next = cnt + slcc_pkg::CNT_W'(src_hit) + slcc_pkg::CNT_W'(tgt_hit);
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (func == slcc_pkg::FUNC_QUERY)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx == IDX_LAST) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state, walk index and running count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      rd_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_WALK);
      if (state == ST_IDLE) begin
        idx <= '0;
        cnt <= '0;
      end else begin
        cnt <= cnt_next;
        if (state == ST_WALK) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_cnt <= cnt;
    end
  end

  assign conflict_count = out_cnt;
  assign prune          = (out_cnt > conflict_limit);

`ifndef ASSERT_OFF
  // No read may be in flight while new items are taken
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !rd_valid)
    else $error("read data pending while idle");

  // Count is bounded by two hits per word position
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= slcc_pkg::CNT_W'(2 * slcc_pkg::MAX_WORDS))
    else $error("conflict count out of range");

  // A new result only appears from the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside done state");

  // The walk ends with a flush state that still consumes read data
  a_flush_follows_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (rd_valid && ($past(state) == ST_WALK)))
    else $error("flush without final read");
`endif

endmodule
